// ===== hw/rtl/u8dc_pkg.sv =====
// Shared types, constants and classification functions for the UTF-8 decoder.
`default_nettype none

package u8dc_pkg;

    // raw byte buffer of a pending sequence: lead plus up to six continuations
    localparam int BUF_DEPTH = 7;

    // result slots of one word's job, emitted lowest first
    localparam int SLOT_N    = 10;   // BUF_DEPTH raw bytes, main, raw byte, tail break
    localparam int SLOT_MAIN = 7;
    localparam int SLOT_RAW  = 8;
    localparam int SLOT_TAIL = 9;

    localparam logic [7:0] LEAD_MIN  = 8'hC0;
    localparam logic [7:0] CONT_SEL  = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    typedef logic [BUF_DEPTH-1:0][7:0] byte_buf_t;

    // everything one input word releases
    typedef struct packed {
        logic [SLOT_N-1:0] mask;        // pending slots
        byte_buf_t         bytes;       // raw bytes of a broken or flushed sequence
        logic [31:0]       main_code;   // decoded code point or held break
        logic [3:0]        main_count;
        logic              main_brk;
        logic [7:0]        raw_byte;    // input byte emitted as itself
        logic              tail_cr;     // held break flushed at end of text
    } job_t;

    function automatic logic space_code(input logic [31:0] c);
        return (c >= 32'h0000_2000 && c <= 32'h0000_200D) ||
               c == 32'h0000_0009 || c == 32'h0000_0020 || c == 32'h0000_00A0 ||
               c == 32'h0000_1680 || c == 32'h0000_180E || c == 32'h0000_202F ||
               c == 32'h0000_205F || c == 32'h0000_2060 || c == 32'h0000_3000 ||
               c == 32'h0000_FEFF;
    endfunction

    function automatic logic break_code(input logic [31:0] c);
        return (c >= 32'h0000_000A && c <= 32'h0000_000D) ||
               c == 32'h0000_0085 || c == 32'h0000_2028 || c == 32'h0000_2029;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8dc_if.sv =====
// Valid/ready channel interfaces for text bytes in and decoded units out.
`default_nettype none

interface u8dc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8dc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;
    logic [3:0]  byte_count;
    logic        is_space;
    logic        is_break;
    logic        run_end;

    modport source (output valid, output code_point, output byte_count, output is_space,
                    output is_break, output run_end, input ready);
    modport sink   (input valid, input code_point, input byte_count, input is_space,
                    input is_break, input run_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8dc_decode.sv =====
// Sequence decoder: holds the partial sequence state and builds the job of each word.
`default_nettype none

module u8dc_decode (
    input  wire logic          clk,
    input  wire logic          rst_n,
    u8dc_in_if.sink            text_in,
    input  wire logic          job_ready,
    output u8dc_pkg::job_t     job_out,
    output logic               job_load
);
    import u8dc_pkg::*;

    logic [31:0] partial_reg, partial_next;
    logic [2:0]  conts_reg, conts_next;
    logic [3:0]  taken_reg, taken_next;
    logic        held_reg, held_next;
    logic        cr_reg, cr_next;
    byte_buf_t   buf_reg, buf_next;

    byte_buf_t   buf_cont;       // buffer with this word's continuation written
    logic [7:0]  b;
    logic        is_cont;
    logic        consumed;
    logic        cont_taken;
    logic        run;
    logic [2:0]  lead_ones;
    logic [7:0]  first_brk;
    logic [7:0]  partner_brk;
    job_t        job;

    function automatic logic [31:0] payload_mask(input logic [3:0] n);
        logic [31:0] m;
        case (n)
            4'd2:    m = 32'h0000_07FF;
            4'd3:    m = 32'h0000_FFFF;
            4'd4:    m = 32'h001F_FFFF;
            4'd5:    m = 32'h03FF_FFFF;
            4'd6:    m = 32'h7FFF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    assign text_in.ready = job_ready;
    assign job_load      = text_in.valid && job_ready;
    assign job_out       = job;

    always_comb
    begin
        b            = text_in.text_byte;
        is_cont      = (b & CONT_SEL) == CONT_TAG;
        partial_next = partial_reg;
        conts_next   = conts_reg;
        taken_next   = taken_reg;
        held_next    = held_reg;
        cr_next      = cr_reg;
        buf_cont     = buf_reg;
        consumed     = 1'b0;
        cont_taken   = 1'b0;
        first_brk    = cr_reg ? CHAR_CR : CHAR_LF;
        partner_brk  = cr_reg ? CHAR_LF : CHAR_CR;

        job            = '0;
        job.raw_byte   = b;
        job.main_code  = '0;

        // leading ones after the top bit give the continuation count
        lead_ones = '0;
        run       = 1'b1;
        for (int i = 6; i >= 0; i--)
        begin
            run = run && b[i];
            if (run)
            begin
                lead_ones = lead_ones + 3'd1;
            end
        end

        if (conts_reg != 3'd0)
        begin
            if (is_cont)
            begin
                partial_next = {partial_reg[25:0], b[5:0]};
                if (taken_reg < 4'(BUF_DEPTH))
                begin
                    buf_cont[taken_reg[2:0]] = b;
                end
                taken_next = taken_reg + 4'd1;
                conts_next = conts_reg - 3'd1;
                if (conts_next == 3'd0)
                begin
                    job.mask[SLOT_MAIN] = 1'b1;
                    job.main_code       = partial_next & payload_mask(taken_next);
                    job.main_count      = taken_next;
                    job.main_brk        = 1'b0;
                    taken_next          = '0;
                    partial_next        = '0;
                end
                consumed   = 1'b1;
                cont_taken = 1'b1;
            end
            else
            begin
                // broken sequence: buffered bytes go out raw
                for (int i = 0; i < BUF_DEPTH; i++)
                begin
                    job.mask[i] = 4'(i) < taken_reg;
                end
                conts_next   = '0;
                taken_next   = '0;
                partial_next = '0;
            end
        end

        if (!consumed && held_reg)
        begin
            held_next           = 1'b0;
            cr_next             = 1'b0;
            job.mask[SLOT_MAIN] = 1'b1;
            job.main_code       = {24'd0, first_brk};
            job.main_brk        = 1'b1;
            if (b == partner_brk)
            begin
                job.main_count = 4'd2;
                consumed       = 1'b1;
            end
            else
            begin
                job.main_count = 4'd1;
            end
        end

        buf_next = buf_cont;
        if (!consumed)
        begin
            if (b >= LEAD_MIN)
            begin
                partial_next = {24'd0, b};
                buf_next[0]  = b;
                taken_next   = 4'd1;
                conts_next   = lead_ones;
            end
            else if (b == CHAR_CR || b == CHAR_LF)
            begin
                held_next = 1'b1;
                cr_next   = b == CHAR_CR;
            end
            else
            begin
                job.mask[SLOT_RAW] = 1'b1;
            end
        end

        if (text_in.end_of_text)
        begin
            if (conts_next != 3'd0)
            begin
                if (cont_taken)
                begin
                    for (int i = 0; i < BUF_DEPTH; i++)
                    begin
                        job.mask[i] = 4'(i) < taken_next;
                    end
                end
                else
                begin
                    job.mask[SLOT_RAW] = 1'b1;   // fresh lead byte alone
                end
            end
            if (held_next)
            begin
                job.mask[SLOT_TAIL] = 1'b1;
                job.tail_cr         = cr_next;
            end
            held_next    = 1'b0;
            cr_next      = 1'b0;
            conts_next   = '0;
            taken_next   = '0;
            partial_next = '0;
        end

        job.bytes = buf_cont;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            conts_reg   <= '0;
            taken_reg   <= '0;
            held_reg    <= 1'b0;
            cr_reg      <= 1'b0;
        end
        else if (job_load)
        begin
            partial_reg <= partial_next;
            conts_reg   <= conts_next;
            taken_reg   <= taken_next;
            held_reg    <= held_next;
            cr_reg      <= cr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            buf_reg <= buf_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/u8dc_emit.sv =====
// Result emitter: walks the pending slots of a job and fills the output register.
`default_nettype none

module u8dc_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire u8dc_pkg::job_t job_in,
    input  wire logic           job_load,
    output logic                job_ready,
    u8dc_out_if.source          unit_out
);
    import u8dc_pkg::*;

    job_t              job_reg;
    logic [SLOT_N-1:0] mask_reg, mask_next;
    logic [SLOT_N-1:0] sel;
    logic              out_valid_reg;
    logic [31:0]       code_reg;
    logic [3:0]        count_reg;
    logic              space_reg, brk_reg, end_reg;

    logic [31:0] code_sel;
    logic [3:0]  count_sel;
    logic        brk_sel;
    logic        out_load;
    logic        advance;

    assign out_load  = !out_valid_reg || unit_out.ready;
    assign advance   = out_load && mask_reg != '0;
    assign sel       = mask_reg & (~mask_reg + {{(SLOT_N-1){1'b0}}, 1'b1});
    assign mask_next = mask_reg & ~sel;
    assign job_ready = mask_reg == '0 || (advance && mask_next == '0);

    always_comb
    begin
        code_sel  = '0;
        count_sel = 4'd1;
        brk_sel   = 1'b0;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            if (sel[i])
            begin
                code_sel = {24'd0, job_reg.bytes[i]};
            end
        end
        if (sel[SLOT_MAIN])
        begin
            code_sel  = job_reg.main_code;
            count_sel = job_reg.main_count;
            brk_sel   = job_reg.main_brk;
        end
        if (sel[SLOT_RAW])
        begin
            code_sel = {24'd0, job_reg.raw_byte};
        end
        if (sel[SLOT_TAIL])
        begin
            code_sel = {24'd0, job_reg.tail_cr ? CHAR_CR : CHAR_LF};
            brk_sel  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_load)
            begin
                mask_reg <= job_in.mask;
            end
            else if (advance)
            begin
                mask_reg <= mask_next;
            end
            if (out_load)
            begin
                out_valid_reg <= mask_reg != '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job_in;
        end
        if (advance)
        begin
            code_reg  <= code_sel;
            count_reg <= count_sel;
            space_reg <= space_code(code_sel);
            brk_reg   <= brk_sel || break_code(code_sel);
            end_reg   <= mask_next == '0;
        end
    end

    assign unit_out.valid      = out_valid_reg;
    assign unit_out.code_point = code_reg;
    assign unit_out.byte_count = count_reg;
    assign unit_out.is_space   = space_reg;
    assign unit_out.is_break   = brk_reg;
    assign unit_out.run_end    = end_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_decode_classify.sv =====
// Top level of the streaming UTF-8 decoder and whitespace/line-break classifier.
`default_nettype none

// Takes one text byte per word on text_in and delivers decoded units on unit_out.
// A lead byte 0xC0-0xFF opens a sequence of one continuation per extra leading
// one (up to seven); the payload is built in 32-bit wraparound and masked to
// 6+5k bits. A non-continuation byte during a sequence flushes the buffered
// bytes raw, one unit each, then is handled afresh; end_of_text flushes the
// same way and releases a held CR or LF. CR LF and LF CR merge into one
// two-byte break, so a lone CR or LF is held until the next byte decides it.
// Each unit carries code point, byte count, whitespace and line-break flags,
// and run_end marks the last unit released by an input word. A word is
// decoded as it is accepted; its results land in a job register and leave
// through the output register. The output side emits one unit per cycle while
// unit_out.ready holds; an input word that releases several units holds the
// emitter until its last unit moves to the output register, and the next word
// is taken only then. Words releasing zero or one unit stream at one per cycle
// while the output does not stall.
// text_in.ready follows unit_out.ready combinationally through the emitter.
// No reset sweep: the byte buffer is only read after being written.

module utf8_decode_classify (
    input  wire logic  clk,
    input  wire logic  rst_n,
    u8dc_in_if.sink    text_in,
    u8dc_out_if.source unit_out
);
    import u8dc_pkg::*;

    job_t job;
    logic job_load;
    logic job_ready;

    // sequence state, byte buffer, job building
    u8dc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .job_ready (job_ready),
        .job_out   (job),
        .job_load  (job_load)
    );

    // slot walker and output register
    u8dc_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_in    (job),
        .job_load  (job_load),
        .job_ready (job_ready),
        .unit_out  (unit_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/u8dc_check.sv =====
// Port-level checker for the UTF-8 decoder, bound to the top level.
`default_nettype none

module u8dc_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] code_point,
    input wire logic [3:0]  byte_count,
    input wire logic        is_space,
    input wire logic        is_break
);

    // a stalled unit stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("unit dropped while stalled");

    // every unit covers one to eight bytes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count != 4'd0 && byte_count <= 4'd8)
        else $error("byte count out of range");

    // whitespace and line-break sets do not overlap
    a_class_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_space && is_break))
        else $error("unit flagged both space and break");

    // single-byte units never carry more than a byte
    a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == 4'd1 |-> code_point[31:8] == 24'd0)
        else $error("single-byte unit with wide code point");

endmodule

bind utf8_decode_classify u8dc_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (unit_out.valid),
    .out_ready  (unit_out.ready),
    .code_point (unit_out.code_point),
    .byte_count (unit_out.byte_count),
    .is_space   (unit_out.is_space),
    .is_break   (unit_out.is_break)
);

`default_nettype wire

// ===== bench/utf8_decode_classify_chk.sv =====
// Scoreboard for the UTF-8 decoder: predicts the units of each accepted word and checks them.
module utf8_decode_classify_chk (
    input  logic clk,
    input  logic rst_n,
    u8dc_in_if   text_in,
    u8dc_out_if  unit_out,
    output int   fail_count,
    output int   pending
);
    import u8dc_pkg::*;

    typedef struct packed {
        logic [31:0] code;
        logic [3:0]  count;
        logic        space;
        logic        brk;
        logic        last;
    } unit_t;

    unit_t       units_due[$];
    unit_t       word_units[$];
    unit_t       seen;

    // decoder shadow state
    logic [31:0] seq_code;
    int unsigned seq_left;
    int unsigned seq_bytes;
    logic [7:0]  seq_raw [BUF_DEPTH];
    logic        nl_held;
    logic        held_cr;

    function automatic logic ws_cp(input logic [31:0] c);
        case (c)
            32'h0009, 32'h0020, 32'h00A0, 32'h1680, 32'h180E, 32'h202F,
            32'h205F, 32'h2060, 32'h3000, 32'hFEFF:
                return 1'b1;
            default:
                return c >= 32'h2000 && c <= 32'h200D;
        endcase
    endfunction

    function automatic logic nl_cp(input logic [31:0] c);
        return (c >= 32'h000A && c <= 32'h000D) || c == 32'h0085 ||
               c == 32'h2028 || c == 32'h2029;
    endfunction

    task automatic add_unit(input logic [31:0] c, input logic [3:0] n, input logic merged);
        unit_t u;
        u.code  = c;
        u.count = n;
        u.space = ws_cp(c);
        u.brk   = merged || nl_cp(c);
        u.last  = 1'b0;
        word_units.push_back(u);
    endtask

    // broken or cut-off sequence: every buffered byte goes out on its own
    task automatic flush_seq();
        int unsigned i;
        for (i = 0; i < seq_bytes && i < BUF_DEPTH; i++)
            add_unit({24'd0, seq_raw[i]}, 4'd1, 1'b0);
        seq_left  = 0;
        seq_bytes = 0;
        seq_code  = '0;
    endtask

    task automatic decode_word(input logic [7:0] b, input logic eot);
        logic        taken;
        logic [7:0]  partner;
        logic [7:0]  first;
        int unsigned nbits;
        logic [31:0] keep;
        int          bit_i;
        unit_t       u;
        taken = 1'b0;
        word_units.delete();

        if (seq_left > 0) begin
            if ((b & CONT_SEL) == CONT_TAG) begin
                seq_code = (seq_code << 6) | {26'd0, b[5:0]};
                if (seq_bytes < BUF_DEPTH)
                    seq_raw[seq_bytes] = b;
                seq_bytes++;
                seq_left--;
                if (seq_left == 0) begin
                    nbits = 6 + 5 * (seq_bytes - 1);
                    keep  = (nbits >= 32) ? '1 : ((32'd1 << nbits) - 32'd1);
                    add_unit(seq_code & keep, 4'(seq_bytes), 1'b0);
                    seq_bytes = 0;
                    seq_code  = '0;
                end
                taken = 1'b1;
            end
            else
                flush_seq();
        end

        if (!taken && nl_held) begin
            first   = held_cr ? CHAR_CR : CHAR_LF;
            partner = held_cr ? CHAR_LF : CHAR_CR;
            nl_held = 1'b0;
            held_cr = 1'b0;
            taken   = (b == partner);
            add_unit({24'd0, first}, taken ? 4'd2 : 4'd1, 1'b1);
        end

        if (!taken) begin
            if (b >= LEAD_MIN) begin
                seq_left = 0;
                for (bit_i = 6; bit_i >= 0; bit_i--) begin
                    if (!b[bit_i])
                        break;
                    seq_left++;
                end
                seq_code   = {24'd0, b};
                seq_raw[0] = b;
                seq_bytes  = 1;
            end
            else if (b == CHAR_CR || b == CHAR_LF) begin
                nl_held = 1'b1;
                held_cr = (b == CHAR_CR);
            end
            else
                add_unit({24'd0, b}, 4'd1, 1'b0);
        end

        if (eot) begin
            if (seq_left > 0)
                flush_seq();
            if (nl_held) begin
                add_unit({24'd0, held_cr ? CHAR_CR : CHAR_LF}, 4'd1, 1'b1);
                nl_held = 1'b0;
                held_cr = 1'b0;
            end
            seq_left  = 0;
            seq_bytes = 0;
            seq_code  = '0;
        end

        if (word_units.size() > 0) begin
            u = word_units.pop_back();
            u.last = 1'b1;
            word_units.push_back(u);
        end
        foreach (word_units[i])
            units_due.push_back(word_units[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            units_due.delete();
            seq_code  = '0;
            seq_left  = 0;
            seq_bytes = 0;
            nl_held   = 1'b0;
            held_cr   = 1'b0;
            pending   = 0;
        end
        else begin
            if (text_in.valid && text_in.ready)
                decode_word(text_in.text_byte, text_in.end_of_text);

            if (unit_out.valid && unit_out.ready) begin
                if (units_due.size() == 0)
                    report_mismatch("unit with none due", unit_out.code_point, '0);
                else begin
                    seen = units_due.pop_front();
                    if (unit_out.code_point !== seen.code)
                        report_mismatch("code_point", unit_out.code_point, seen.code);
                    if (unit_out.byte_count !== seen.count)
                        report_mismatch("byte_count", 32'(unit_out.byte_count),
                                        32'(seen.count));
                    if (unit_out.is_space !== seen.space)
                        report_mismatch("is_space", 32'(unit_out.is_space), 32'(seen.space));
                    if (unit_out.is_break !== seen.brk)
                        report_mismatch("is_break", 32'(unit_out.is_break), 32'(seen.brk));
                    if (unit_out.run_end !== seen.last)
                        report_mismatch("run_end", 32'(unit_out.run_end), 32'(seen.last));
                end
            end
            pending = units_due.size();
        end
    end

endmodule

// ===== bench/utf8_decode_classify_tb.sv =====
// Top of the UTF-8 decoder bench: clock, reset, word stimulus, unit sink and verdict.
module utf8_decode_classify_tb;
    import u8dc_pkg::*;

    localparam int RANDOM_WORDS = 200;
    localparam int DRAIN_CYCLES = 20;     // first unit passes the job and output registers after its word
    localparam int NUM_MARKED   = 14;

    // code points with a whitespace or line-break class, sent properly encoded
    localparam logic [31:0] MARKED_CP [NUM_MARKED] = '{
        32'h0009, 32'h0020, 32'h00A0, 32'h0085, 32'h1680, 32'h180E, 32'h200D,
        32'h2028, 32'h2029, 32'h202F, 32'h205F, 32'h2060, 32'h3000, 32'hFEFF
    };

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    // idle-free stretches, one counter per side
    int   send_calm = 0;
    int   sink_calm = 0;

    // bytes of the unit being sent in the random part
    logic [7:0] burst_q[$];

    u8dc_in_if  text_in();
    u8dc_out_if unit_out();

    utf8_decode_classify i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .unit_out (unit_out)
    );

    utf8_decode_classify_chk i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .unit_out   (unit_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: the slowest legal run (every word with its full gap, every
    // unit with a full stall) stays well under a tenth of this.
    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Draws a random wait before the next word or unit, except inside a calm
    // stretch, where the side runs flat out.
    function automatic int unsigned draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(8, 30);
        return $urandom_range(0, 8);
    endfunction

    // One word on text_in. Everything changes at the falling edge; the word
    // counts as taken at the rising edge where valid and ready are both high.
    // A word that follows with no gap keeps valid high without a dip.
    task automatic send_word(input logic [7:0] b, input logic eot);
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            @(negedge clk);
            text_in.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        text_in.valid       = 1'b1;
        text_in.text_byte   = b;
        text_in.end_of_text = eot;
        do
            @(posedge clk);
        while (!(text_in.valid && text_in.ready));
    endtask

    // Proper UTF-8 for code points up to 0xFFFF.
    task automatic put_cp(input logic [31:0] c);
        if (c < 32'h80)
            burst_q.push_back(c[7:0]);
        else if (c < 32'h800) begin
            burst_q.push_back(8'hC0 | {3'd0, c[10:6]});
            burst_q.push_back(CONT_TAG | {2'd0, c[5:0]});
        end
        else begin
            burst_q.push_back(8'hE0 | {4'd0, c[15:12]});
            burst_q.push_back(CONT_TAG | {2'd0, c[11:6]});
            burst_q.push_back(CONT_TAG | {2'd0, c[5:0]});
        end
    endtask

    // Builds the bytes of one random unit. About half are well-formed sequences
    // with random payload so the decoder gets past its lead state; the rest is
    // ASCII, CR/LF mixes, cut-off sequences and arbitrary bytes.
    task automatic make_unit();
        int unsigned kind;
        int unsigned k;
        int unsigned drop;
        int unsigned i;
        logic [7:0]  lead;
        burst_q.delete();
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:
            begin
                case ($urandom_range(0, 5))
                    0:       burst_q.push_back(CHAR_CR);
                    1:       burst_q.push_back(CHAR_LF);
                    2:       burst_q.push_back(8'h20);
                    3:       burst_q.push_back(8'h09);
                    default: burst_q.push_back(8'($urandom_range(0, 127)));
                endcase
            end
            2:
            begin
                if ($urandom_range(0, 3) == 0)
                    put_cp(32'h2000 + $urandom_range(0, 13));
                else
                    put_cp(MARKED_CP[$urandom_range(0, NUM_MARKED - 1)]);
            end
            3, 4, 5, 6, 7:
            begin
                // short sequences most of the time, long ones now and then
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
                lead = 8'hFF << (7 - k);
                if (k < 7)
                    lead = lead | (8'($urandom) & ((8'h01 << (6 - k)) - 8'h01));
                burst_q.push_back(lead);
                // kind 7 leaves the sequence short; the next unit breaks it unless it starts with a continuation byte
                drop = (kind == 7) ? $urandom_range(1, k) : 0;
                for (i = 0; i < k - drop; i++)
                    burst_q.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
            end
            8:
                burst_q.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                // CR/LF runs: merges, repeats and lone breaks
                for (i = 0; i < $urandom_range(2, 3); i++)
                    burst_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end
        endcase
    endtask

    // Unit sink: ready drops for a drawn number of cycles before each unit,
    // then stays high until a unit is taken.
    initial
    begin : unit_sink
        int unsigned gap;
        unit_out.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = draw_gap(sink_calm);
            if (gap > 0) begin
                @(negedge clk);
                unit_out.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            unit_out.ready = 1'b1;
            do
                @(posedge clk);
            while (!(unit_out.valid && unit_out.ready));
        end
    end

    initial
    begin : word_source
        int unsigned sent;
        int unsigned i;
        text_in.valid       = 1'b0;
        text_in.text_byte   = '0;
        text_in.end_of_text = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        send_word(8'h20, 1'b0);                           // plain space
        send_word(8'h85, 1'b0);                           // lone continuation, a break code
        send_word(CHAR_CR, 1'b0);                         // CR held ...
        send_word(CHAR_LF, 1'b0);                         // ... merges into CR LF
        send_word(CHAR_LF, 1'b0);
        send_word(CHAR_LF, 1'b0);                         // LF alone, new LF held
        send_word(CHAR_CR, 1'b0);                         // LF CR merge
        send_word(8'hC0, 1'b0);                           // overlong CR: break at once,
        send_word(8'h8D, 1'b0);                           // two bytes, no merge
        send_word(8'hE3, 1'b0);                           // sequence broken by a CR:
        send_word(CONT_TAG, 1'b0);                        // E3 and 80 go out raw,
        send_word(CHAR_CR, 1'b0);                         // CR is held
        send_word(8'hFF, 1'b0);                           // longest lead, frees the CR
        for (i = 0; i < 7; i++)
            send_word(8'hBF, 1'b0);                       // all-ones code point, 8 bytes
        send_word(8'hF0, 1'b0);                           // cut off by end of text:
        send_word(8'h90, 1'b1);                           // flushed raw
        send_word(CHAR_CR, 1'b1);                         // held CR flushed by end of text
        send_word(8'hE2, 1'b0);                           // U+2028 line separator
        send_word(8'h80, 1'b0);
        send_word(8'hA8, 1'b0);

        // --- random part ---
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            make_unit();
            foreach (burst_q[j]) begin
                send_word(burst_q[j], $urandom_range(0, 39) == 0);
                sent++;
            end
        end
        // last word closes the text so nothing stays held
        send_word(8'($urandom_range(0, 255)), 1'b1);
        @(negedge clk);
        text_in.valid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
